[hw/rtl/dogx_pkg.sv]
package dogx_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int ROW_LIMIT   = 1024;

    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(ROW_LIMIT);
    localparam int DIM_BITS    = 11;
    localparam int THR_BITS    = 15;
    localparam int SHIFT_BITS  = 3;
    localparam int KEY_BITS    = 17;
    localparam int EW_BITS     = (COL_BITS + 1 > DIM_BITS) ? COL_BITS + 1 : DIM_BITS;
    localparam int EH_BITS     = ROW_BITS + 1;
    localparam int MAG_BITS    = SAMPLE_BITS + 1;
    localparam int CMP_BITS    = (MAG_BITS > THR_BITS) ? MAG_BITS + 1 : THR_BITS + 1;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 4;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_PEAK_THRESHOLD = 2'd2,
        REG_OCTAVE_SHIFT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] lo;
        logic signed [SAMPLE_BITS-1:0] ce;
        logic signed [SAMPLE_BITS-1:0] up;
    } t_triple;

endpackage

[hw/rtl/dog_extremum_detector_unit.sv]
// 3x3x3 difference-of-Gaussian extremum detector on a raster pixel stream. Each input
// transaction carries the co-located samples of the scale below, the tested scale and the
// scale above; a result transaction is issued for every pixel whose tested-scale sample is
// strictly above or strictly below all 26 neighbors and whose magnitude exceeds
// peak_threshold. The first and last rows and columns are never tested. One pixel is taken
// every clock while the output is not held; the result that a pixel completes is carried from
// the input register and line store read through the window shift and compare into the output
// register, and a held output stalls it on the way. The two line stores are single-write,
// single-read memories of MAX_WIDTH entries and are not cleared: the first two rows of the
// first frame after reset only prime them. Assert start_of_frame on the first pixel of a
// frame; positions also wrap at frame_width and frame_height. Write registers only while
// the block is idle.
module dog_extremum_detector_unit
    import dogx_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_AW-1:0]             paddr,
    input  logic [APB_DW-1:0]             pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_lower_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_center_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_upper_sample,
    input  logic                          i_start_of_frame,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [KEY_BITS-1:0]           o_key_x,
    output logic [KEY_BITS-1:0]           o_key_y,
    output logic                          o_is_maximum,
    output logic signed [SAMPLE_BITS-1:0] o_peak_value
);

    // configuration
    logic [DIM_BITS-1:0]   r_frame_width;
    logic [DIM_BITS-1:0]   r_frame_height;
    logic [THR_BITS-1:0]   r_peak_threshold;
    logic [SHIFT_BITS-1:0] r_octave_shift;
    logic                  cfg_wr;
    t_reg_idx              cfg_idx;

    // position counters
    logic [COL_BITS-1:0]   r_col;
    logic [ROW_BITS-1:0]   r_row;
    logic [EW_BITS-1:0]    eff_w;
    logic [EH_BITS-1:0]    eff_h;
    logic [COL_BITS-1:0]   col_in;
    logic [ROW_BITS-1:0]   row_in;
    logic [EW_BITS-1:0]    col_p1;
    logic [EH_BITS-1:0]    row_p1;
    logic [COL_BITS-1:0]   n_col;
    logic [ROW_BITS-1:0]   n_row;

    // line stores
    t_triple               mem_older [MAX_WIDTH];
    t_triple               mem_newer [MAX_WIDTH];
    t_triple               r_rd_older;
    t_triple               r_rd_newer;
    logic                  r_fwd;
    t_triple               r_fwd_older;
    t_triple               r_fwd_newer;
    t_triple               s1_older;
    t_triple               s1_newer;

    // stage 1: accepted pixel
    logic                  r_s1_valid;
    t_triple               r_s1_cur;
    logic [COL_BITS-1:0]   r_s1_col;
    logic [ROW_BITS-1:0]   r_s1_row;

    // stage 2: window
    logic                  r_s2_valid;
    logic                  r_s2_test;
    logic [COL_BITS-1:0]   r_s2_col;
    logic [ROW_BITS-1:0]   r_s2_row;
    t_triple               r_win [3][3];

    // output register
    logic                  r_out_valid;
    logic [KEY_BITS-1:0]   r_key_x;
    logic [KEY_BITS-1:0]   r_key_y;
    logic                  r_is_max;
    logic signed [SAMPLE_BITS-1:0] r_peak;

    // handshake
    logic                  in_accept;
    logic                  en_out;
    logic                  free2;
    logic                  free1;
    logic                  en1;

    // compare
    logic signed [SAMPLE_BITS-1:0] center;
    logic                  is_max;
    logic                  is_min;
    logic [MAG_BITS-1:0]   ext;
    logic [MAG_BITS-1:0]   mag;
    logic                  hit;
    logic [COL_BITS-1:0]   kx_base;
    logic [ROW_BITS-1:0]   ky_base;

    //--------------------------------------------------------------------
    // Configuration port
    //--------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:    prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT:   prdata = APB_DW'(r_frame_height);
            REG_PEAK_THRESHOLD: prdata = APB_DW'(r_peak_threshold);
            REG_OCTAVE_SHIFT:   prdata = APB_DW'(r_octave_shift);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= DIM_BITS'(640);
            r_frame_height   <= DIM_BITS'(480);
            r_peak_threshold <= THR_BITS'(492);
            r_octave_shift   <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:    r_frame_width    <= pwdata[DIM_BITS-1:0];
                REG_FRAME_HEIGHT:   r_frame_height   <= pwdata[DIM_BITS-1:0];
                REG_PEAK_THRESHOLD: r_peak_threshold <= pwdata[THR_BITS-1:0];
                REG_OCTAVE_SHIFT:   r_octave_shift   <= pwdata[SHIFT_BITS-1:0];
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Flow control: each stage moves when the one after it is empty or moving
    //--------------------------------------------------------------------
    assign en_out     = !r_out_valid || !i_out_stall;
    assign free2      = !r_s2_valid || en_out;
    assign en1        = r_s1_valid && free2;
    assign free1      = !r_s1_valid || free2;
    assign o_in_stall = !free1;
    assign in_accept  = i_in_valid && free1;

    //--------------------------------------------------------------------
    // Position of the incoming pixel
    //--------------------------------------------------------------------
    always_comb begin
        if (EW_BITS'(r_frame_width) < EW_BITS'(3)) begin
            eff_w = EW_BITS'(3);
        end else if (EW_BITS'(r_frame_width) > EW_BITS'(MAX_WIDTH)) begin
            eff_w = EW_BITS'(MAX_WIDTH);
        end else begin
            eff_w = EW_BITS'(r_frame_width);
        end
        if (r_frame_height < DIM_BITS'(3)) begin
            eff_h = EH_BITS'(3);
        end else if (r_frame_height > DIM_BITS'(ROW_LIMIT)) begin
            eff_h = EH_BITS'(ROW_LIMIT);
        end else begin
            eff_h = EH_BITS'(r_frame_height);
        end

        if (i_start_of_frame || EW_BITS'(r_col) >= eff_w) begin
            col_in = '0;
        end else begin
            col_in = r_col;
        end
        if (i_start_of_frame || EH_BITS'(r_row) >= eff_h) begin
            row_in = '0;
        end else begin
            row_in = r_row;
        end

        col_p1 = EW_BITS'(col_in) + EW_BITS'(1);
        row_p1 = EH_BITS'(row_in) + EH_BITS'(1);
        if (col_p1 >= eff_w) begin
            n_col = '0;
            n_row = (row_p1 >= eff_h) ? '0 : row_p1[ROW_BITS-1:0];
        end else begin
            n_col = col_p1[COL_BITS-1:0];
            n_row = row_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    //--------------------------------------------------------------------
    // Line stores: read on accept, write when the pixel enters the window
    //--------------------------------------------------------------------
    assign s1_older = r_fwd ? r_fwd_older : r_rd_older;
    assign s1_newer = r_fwd ? r_fwd_newer : r_rd_newer;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            mem_older[r_s1_col] <= s1_newer;
            mem_newer[r_s1_col] <= r_s1_cur;
        end
        if (in_accept) begin
            r_rd_older <= mem_older[col_in];
            r_rd_newer <= mem_newer[col_in];
        end
    end

    // bypass the write in flight when a restarted frame hits the same column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_accept) begin
            r_fwd <= en1 && (r_s1_col == col_in);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd_older <= s1_newer;
            r_fwd_newer <= r_s1_cur;
        end
    end

    //--------------------------------------------------------------------
    // Stage 1
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (free1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cur.lo <= i_lower_sample;
            r_s1_cur.ce <= i_center_sample;
            r_s1_cur.up <= i_upper_sample;
            r_s1_col    <= col_in;
            r_s1_row    <= row_in;
        end
    end

    //--------------------------------------------------------------------
    // Stage 2: shift window, insert new column
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (free2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= s1_older;
            r_win[1][2] <= s1_newer;
            r_win[2][2] <= r_s1_cur;
            r_s2_col    <= r_s1_col;
            r_s2_row    <= r_s1_row;
            r_s2_test   <= (r_s1_row >= ROW_BITS'(2)) && (r_s1_col >= COL_BITS'(2));
        end
    end

    //--------------------------------------------------------------------
    // 26-neighbor compare and threshold
    //--------------------------------------------------------------------
    always_comb begin
        center = r_win[1][1].ce;
        is_max = 1'b1;
        is_min = 1'b1;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (center <= r_win[r][c].lo) is_max = 1'b0;
                if (center >= r_win[r][c].lo) is_min = 1'b0;
                if (center <= r_win[r][c].up) is_max = 1'b0;
                if (center >= r_win[r][c].up) is_min = 1'b0;
                if (!(r == 1 && c == 1)) begin
                    if (center <= r_win[r][c].ce) is_max = 1'b0;
                    if (center >= r_win[r][c].ce) is_min = 1'b0;
                end
            end
        end
        ext     = {center[SAMPLE_BITS-1], center};
        mag     = ext[MAG_BITS-1] ? (~ext + MAG_BITS'(1)) : ext;
        hit     = r_s2_valid && r_s2_test && (is_max || is_min)
                  && (CMP_BITS'(mag) > CMP_BITS'(r_peak_threshold));
        kx_base = r_s2_col - COL_BITS'(1);
        ky_base = r_s2_row - ROW_BITS'(1);
    end

    //--------------------------------------------------------------------
    // Output register
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && hit) begin
            r_key_x  <= KEY_BITS'(KEY_BITS'(kx_base) << r_octave_shift);
            r_key_y  <= KEY_BITS'(KEY_BITS'(ky_base) << r_octave_shift);
            r_is_max <= is_max;
            r_peak   <= center;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_x      = r_key_x;
    assign o_key_y      = r_key_y;
    assign o_is_maximum = r_is_max;
    assign o_peak_value = r_peak;

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid && r_out_valid))
        else $error("input stalled with an empty stage");

    a_result_from_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid))
        else $error("result without a window in flight");

    a_no_border_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_test) |-> (r_s2_col >= COL_BITS'(2) && r_s2_row >= ROW_BITS'(2)))
        else $error("border pixel tested");

    a_extremum_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> !(is_max && is_min))
        else $error("pixel both maximum and minimum");

endmodule
